### rtl/mtcd_pkg.sv
// Shared types, constants and calendar helpers for the tick to date converter.
package mtcd_pkg;

	// Datapath widths.
	localparam int DVD_W  = 32;
	localparam int DIV_W  = 11;
	localparam int RCP_W  = 29;
	localparam int PROD_W = DVD_W + RCP_W;
	localparam int YEAR_W = 9;

	// Division passes, in the order they run.
	localparam logic [1:0] PH_MS   = 2'd0;
	localparam logic [1:0] PH_SEC  = 2'd1;
	localparam logic [1:0] PH_MIN  = 2'd2;
	localparam logic [1:0] PH_HOUR = 2'd3;

	// Divisors of the four passes.
	localparam logic [DIV_W-1:0] DIV_MS   = 11'd1000;
	localparam logic [DIV_W-1:0] DIV_SEC  = 11'd60;
	localparam logic [DIV_W-1:0] DIV_MIN  = 11'd60;
	localparam logic [DIV_W-1:0] DIV_HOUR = 11'd24;

	// Reciprocals of the divisors. The quotient is the product shifted right by 38 for
	// the millisecond pass, 29 for both sixty passes and 16 for the hour pass; each is
	// exact over the dividend range of its pass.
	localparam logic [RCP_W-1:0] RCP_MS    = 29'd274877907;
	localparam logic [RCP_W-1:0] RCP_SIXTY = 29'd8947849;
	localparam logic [RCP_W-1:0] RCP_HOUR  = 29'd2731;

	// Configuration register indexes.
	localparam logic [2:0] REG_YEAR   = 3'd0;
	localparam logic [2:0] REG_MONTH  = 3'd1;
	localparam logic [2:0] REG_DAY    = 3'd2;
	localparam logic [2:0] REG_HOUR   = 3'd3;
	localparam logic [2:0] REG_MINUTE = 3'd4;
	localparam logic [2:0] REG_SECOND = 3'd5;
	localparam logic [2:0] REG_TICK   = 3'd6;
	localparam logic [2:0] REG_VALID  = 3'd7;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_XFER,
		ST_MONTH,
		ST_HOLD
	} state_t;

	typedef struct packed {
		logic [7:0]  year;
		logic [7:0]  month;
		logic [7:0]  day;
		logic [7:0]  hour;
		logic [7:0]  minute;
		logic [7:0]  second;
		logic [31:0] tick;
		logic        valid;
	} anchor_t;

	typedef struct packed {
		logic       start;
		logic       div_step;
		logic       div_next;
		logic       walk_step;
		logic       load_out;
		logic [1:0] phase;
	} cmd_t;

	typedef struct packed {
		logic anchor_bad;
		logic walk_done;
	} status_t;

	typedef struct packed {
		logic [7:0] year;
		logic [3:0] month;
		logic [4:0] day;
		logic [4:0] hour;
		logic [5:0] minute;
		logic [5:0] second;
	} result_t;

	// Leap test on a year kept as an offset from 2000, which is itself a
	// multiple of 400. Within nine bits the century years that are not leap
	// years are 100, 200, 300 and 500.
	function automatic logic is_leap(input logic [YEAR_W-1:0] y);
		logic century;
		century = (y == 9'd100) || (y == 9'd200) || (y == 9'd300) || (y == 9'd500);
		return (y[1:0] == 2'b00) && !century;
	endfunction

	// Days in a month numbered 1 to 12.
	function automatic logic [4:0] month_days(input logic [3:0] m, input logic leap);
		logic [4:0] d;
		case (m) inside
			4'd4, 4'd6, 4'd9, 4'd11: d = 5'd30;
			4'd2:                    d = leap ? 5'd29 : 5'd28;
			default:                 d = 5'd31;
		endcase
		return d;
	endfunction

endpackage

### rtl/mtcd_tick_if.sv
// Input channel interface carrying one millisecond tick per beat.
interface mtcd_tick_if;
	logic        valid;
	logic        ready;
	logic [31:0] tick_ms;

	modport source(output valid, output tick_ms, input ready);
	modport sink(input valid, input tick_ms, output ready);
endinterface

### rtl/mtcd_dt_if.sv
// Output channel interface carrying one calendar date and time per beat.
interface mtcd_dt_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_year;
	logic [3:0] out_month;
	logic [4:0] out_day;
	logic [4:0] out_hour;
	logic [5:0] out_minute;
	logic [5:0] out_second;

	modport source(
		output valid, output out_year, output out_month, output out_day,
		output out_hour, output out_minute, output out_second, input ready
	);
	modport sink(
		input valid, input out_year, input out_month, input out_day,
		input out_hour, input out_minute, input out_second, output ready
	);
endinterface

### rtl/mtcd_cfg_if.sv
// Configuration write channel interface: register index and write data per beat.
interface mtcd_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [31:0] data;

	modport source(output valid, output index, output data, input ready);
	modport sink(input valid, input index, input data, output ready);
endinterface

### rtl/ms_tick_to_calendar_datetime.sv
// Top level of the millisecond tick to calendar date and time converter.
//
//  Channel  Role    Payload                                     Beat when
//  tick     sink    tick_ms[31:0]                               tick.valid & tick.ready
//  dt       source  out_year, out_month, out_day, out_hour,     dt.valid & dt.ready
//                   out_minute, out_second
//  cfg      sink    index[2:0], data[31:0]                      cfg.valid & cfg.ready
//
// An item runs from its input beat through an accept step, four passes of the shared
// reciprocal divider (a product step, then a quotient and remainder step each, by 1000,
// 60, 60 and 24), the month walk, and a load; the next input beat is taken after the load.
// With an invalid anchor the item goes from the beat straight to the load of the default result.
// Reset is asynchronous and clears the anchor registers and the controller; cfg is always
// ready. A stalled output beat holds in its register while the next item is converted.
module ms_tick_to_calendar_datetime (
	input logic      clk,
	input logic      arst_n,
	mtcd_tick_if.sink  tick,
	mtcd_dt_if.source  dt,
	mtcd_cfg_if.sink   cfg
);
	import mtcd_pkg::*;

	anchor_t anchor;
	cmd_t    cmd;
	status_t status;
	result_t result;

	mtcd_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (cfg.valid),
		.wr_ready (cfg.ready),
		.wr_index (cfg.index),
		.wr_data  (cfg.data),
		.anchor   (anchor)
	);

	mtcd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (tick.valid),
		.in_ready  (tick.ready),
		.out_valid (dt.valid),
		.out_ready (dt.ready),
		.status    (status),
		.cmd       (cmd)
	);

	mtcd_dpath u_dpath (
		.clk     (clk),
		.tick_ms (tick.tick_ms),
		.anchor  (anchor),
		.cmd     (cmd),
		.status  (status),
		.result  (result)
	);

	// Output payload straight from the result register.
	assign dt.out_year   = result.year;
	assign dt.out_month  = result.month;
	assign dt.out_day    = result.day;
	assign dt.out_hour   = result.hour;
	assign dt.out_minute = result.minute;
	assign dt.out_second = result.second;

endmodule

### rtl/mtcd_cfg_regs.sv
// Anchor configuration registers written through the configuration channel.
module mtcd_cfg_regs (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr_valid,
	output logic              wr_ready,
	input  logic [2:0]        wr_index,
	input  logic [31:0]       wr_data,
	output mtcd_pkg::anchor_t anchor
);
	import mtcd_pkg::*;

	anchor_t anchor_q;

	// Writes are always taken.
	assign wr_ready = 1'b1;
	assign anchor   = anchor_q;

	// Register file, all fields clear at reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			anchor_q <= '0;
		end else if (wr_valid) begin
			case (wr_index)
				REG_YEAR:   anchor_q.year   <= wr_data[7:0];
				REG_MONTH:  anchor_q.month  <= wr_data[7:0];
				REG_DAY:    anchor_q.day    <= wr_data[7:0];
				REG_HOUR:   anchor_q.hour   <= wr_data[7:0];
				REG_MINUTE: anchor_q.minute <= wr_data[7:0];
				REG_SECOND: anchor_q.second <= wr_data[7:0];
				REG_TICK:   anchor_q.tick   <= wr_data;
				REG_VALID:  anchor_q.valid  <= wr_data[0];
				default:    anchor_q <= anchor_q;
			endcase
		end
	end

endmodule

### rtl/mtcd_dpath.sv
// Datapath: shared reciprocal divider, time of day fields, month walk and result register.
module mtcd_dpath (
	input  logic              clk,
	input  logic [31:0]       tick_ms,
	input  mtcd_pkg::anchor_t anchor,
	input  mtcd_pkg::cmd_t    cmd,
	output mtcd_pkg::status_t status,
	output mtcd_pkg::result_t result
);
	import mtcd_pkg::*;

	logic [DVD_W-1:0]  dvd_q;
	logic [PROD_W-1:0] prod_q;
	logic              bad_q;
	logic [5:0]        sec_q;
	logic [5:0]        min_q;
	logic [4:0]        hour_q;
	logic [7:0]        day_q;
	logic [3:0]        month_q;
	logic [YEAR_W-1:0] year_q;
	result_t           result_q;

	logic [DIV_W-1:0]  divisor;
	logic [RCP_W-1:0]  recip;
	logic [DVD_W-1:0]  quo;
	logic [DVD_W-1:0]  quo_x_div;
	logic [DVD_W-1:0]  rem;
	logic [13:0]       min_secs;
	logic [19:0]       hour_secs;
	logic [DVD_W-1:0]  secs;
	logic [4:0]        dim;

	// Divisor and reciprocal of the running pass.
	always_comb begin
		case (cmd.phase)
			PH_MS: begin
				divisor = DIV_MS;
				recip   = RCP_MS;
			end
			PH_SEC: begin
				divisor = DIV_SEC;
				recip   = RCP_SIXTY;
			end
			PH_MIN: begin
				divisor = DIV_MIN;
				recip   = RCP_SIXTY;
			end
			PH_HOUR: begin
				divisor = DIV_HOUR;
				recip   = RCP_HOUR;
			end
			default: begin
				divisor = DIV_MS;
				recip   = RCP_MS;
			end
		endcase
	end

	// Quotient from the registered product; the remainder is what the quotient leaves over.
	always_comb begin
		case (cmd.phase)
			PH_MS:   quo = {9'd0, prod_q[PROD_W-1:38]};
			PH_SEC:  quo = prod_q[PROD_W-1:29];
			PH_MIN:  quo = prod_q[PROD_W-1:29];
			PH_HOUR: quo = prod_q[47:16];
			default: quo = {9'd0, prod_q[PROD_W-1:38]};
		endcase
	end

	assign quo_x_div = quo * {{(DVD_W-DIV_W){1'b0}}, divisor};
	assign rem       = dvd_q - quo_x_div;

	// Anchor time of day in seconds, added to the elapsed seconds.
	assign min_secs  = {6'd0, anchor.minute} * 14'd60;
	assign hour_secs = {12'd0, anchor.hour} * 20'd3600;
	assign secs      = quo + DVD_W'(anchor.second) + DVD_W'(min_secs) + DVD_W'(hour_secs);

	// Length of the current month in the walk.
	assign dim = month_days(month_q, is_leap(year_q));

	assign status.anchor_bad = !anchor.valid || anchor.month == 8'd0 || anchor.month > 8'd12
		|| anchor.day == 8'd0 || anchor.day > 8'd31;
	assign status.walk_done  = day_q <= {3'd0, dim};

	// Divider registers and the fields that each pass leaves behind.
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			dvd_q <= tick_ms - anchor.tick;
			bad_q <= status.anchor_bad;
		end else if (cmd.div_step) begin
			prod_q <= {{RCP_W{1'b0}}, dvd_q} * {{DVD_W{1'b0}}, recip};
		end else if (cmd.div_next) begin
			case (cmd.phase)
				PH_MS: begin
					dvd_q <= secs;
				end
				PH_SEC: begin
					sec_q <= rem[5:0];
					dvd_q <= quo;
				end
				PH_MIN: begin
					min_q <= rem[5:0];
					dvd_q <= quo;
				end
				PH_HOUR: begin
					hour_q  <= rem[4:0];
					day_q   <= anchor.day + quo[7:0];
					month_q <= anchor.month[3:0];
					year_q  <= {1'b0, anchor.year};
				end
				default: dvd_q <= secs;
			endcase
		end

		// Month walk: take one month's length off the day count.
		if (cmd.walk_step) begin
			day_q <= day_q - {3'd0, dim};
			if (month_q == 4'd12) begin
				month_q <= 4'd1;
				year_q  <= year_q + 1'b1;
			end else begin
				month_q <= month_q + 1'b1;
			end
		end
	end

	// Result register, loaded once per item.
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			if (bad_q) begin
				result_q <= '{year: 8'd0, month: 4'd1, day: 5'd1,
					hour: 5'd0, minute: 6'd0, second: 6'd0};
			end else begin
				result_q <= '{year: year_q[7:0], month: month_q, day: day_q[4:0],
					hour: hour_q, minute: min_q, second: sec_q};
			end
		end
	end

	assign result = result_q;

	// In the walk the month stays a real month number.
	assert property (@(posedge clk) cmd.walk_step |-> (month_q >= 4'd1 && month_q <= 4'd12))
		else $error("month walk on a month number outside 1 to 12");

endmodule

### rtl/mtcd_ctrl.sv
// Controller: sequences the four division passes, the month walk and the output beat.
module mtcd_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  mtcd_pkg::status_t status,
	output mtcd_pkg::cmd_t    cmd
);
	import mtcd_pkg::*;

	state_t     state_q;
	state_t     state_d;
	logic [1:0] phase_q;
	logic       out_valid_q;

	// State, pass counter and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			phase_q     <= PH_MS;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.start) begin
				phase_q <= PH_MS;
			end else if (cmd.div_next) begin
				phase_q <= phase_q + 1'b1;
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Next state and commands.
	always_comb begin
		state_d       = state_q;
		cmd           = '0;
		cmd.phase     = phase_q;
		in_ready      = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready  = 1'b1;
				cmd.start = in_valid;
				if (in_valid) begin
					state_d = status.anchor_bad ? ST_HOLD : ST_DIV;
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				state_d      = ST_XFER;
			end
			ST_XFER: begin
				cmd.div_next = 1'b1;
				state_d      = (phase_q == PH_HOUR) ? ST_MONTH : ST_DIV;
			end
			ST_MONTH: begin
				if (status.walk_done) begin
					state_d = ST_HOLD;
				end else begin
					cmd.walk_step = 1'b1;
				end
			end
			ST_HOLD: begin
				if (!out_valid_q || out_ready) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign out_valid = out_valid_q;

	// A new result is loaded only into a free or draining output register.
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!out_valid_q || out_ready))
		else $error("result loaded over a waiting beat");

	// Output valid rises only after a result load.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(cmd.load_out))
		else $error("output valid without a result load");

	// An accepted item with a good anchor starts with the millisecond pass.
	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.start && !status.anchor_bad) |=> (state_q == ST_DIV && phase_q == PH_MS))
		else $error("division did not start cleanly");

	// The month walk begins only after the last pass.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MONTH && $past(state_q) == ST_XFER) |-> $past(phase_q) == PH_HOUR)
		else $error("month walk entered before the hour pass");

endmodule
